@@ hw/rtl/modular_exponentiation_assert.svh @@
// Assertion macros for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular_exponentiation: assertion failed");
// Next-cycle implication.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular_exponentiation: assertion failed");
`else
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/mexp_pkg.sv @@
// Package: payload types, microcode encoding and program for modular exponentiation.
package mexp_pkg;

    localparam int VALUE_W = 62;
    localparam int CNT_W   = $clog2(VALUE_W);
    localparam int PC_W    = 3;
    localparam int OP_W    = 3;
    localparam int COND_W  = 3;

    localparam logic [VALUE_W-1:0] ONE_VALUE = {{(VALUE_W-1){1'b0}}, 1'b1};

    // Register indexes on the configuration port
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] message;
        logic               last_word;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               out_of_range;
        logic               last_out;
    } t_result;

    // Program steps
    localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] PC_REM   = 3'd1;
    localparam logic [PC_W-1:0] PC_INIT  = 3'd2;
    localparam logic [PC_W-1:0] PC_MLOAD = 3'd3;
    localparam logic [PC_W-1:0] PC_MSTEP = 3'd4;
    localparam logic [PC_W-1:0] PC_EUPD  = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT  = 3'd6;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_REM   = 3'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 3'd2;
    localparam logic [OP_W-1:0] OP_MLOAD = 3'd3;
    localparam logic [OP_W-1:0] OP_MSTEP = 3'd4;
    localparam logic [OP_W-1:0] OP_EUPD  = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT  = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP   = 3'd7;

    // Jump conditions
    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
    localparam logic [COND_W-1:0] COND_START    = 3'd1;
    localparam logic [COND_W-1:0] COND_CNT_ZERO = 3'd2;
    localparam logic [COND_W-1:0] COND_E_ZERO   = 3'd3;
    localparam logic [COND_W-1:0] COND_Y_LAST   = 3'd4;
    localparam logic [COND_W-1:0] COND_E_LAST   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   tgt_t;   // taken when cond holds
        logic [PC_W-1:0]   tgt_f;
    } t_uword;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:  w = '{OP_LOAD,  COND_START,    PC_REM,   PC_IDLE};
            PC_REM:   w = '{OP_REM,   COND_CNT_ZERO, PC_INIT,  PC_REM};
            PC_INIT:  w = '{OP_INIT,  COND_E_ZERO,   PC_EMIT,  PC_MLOAD};
            PC_MLOAD: w = '{OP_MLOAD, COND_ALWAYS,   PC_MSTEP, PC_MSTEP};
            PC_MSTEP: w = '{OP_MSTEP, COND_Y_LAST,   PC_EUPD,  PC_MSTEP};
            PC_EUPD:  w = '{OP_EUPD,  COND_E_LAST,   PC_EMIT,  PC_MLOAD};
            PC_EMIT:  w = '{OP_EMIT,  COND_ALWAYS,   PC_IDLE,  PC_IDLE};
            default:  w = '{OP_NOP,   COND_ALWAYS,   PC_IDLE,  PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/modular_exponentiation.sv @@
// Modular exponentiation: microcoded square-and-multiply over a shift-and-add datapath.
//
// Usage
//   Request channel: drive i_req (message, last_word) and raise start; the request
//   is taken at the rising edge where start is high and busy is low. busy is high
//   from the cycle after that edge until the cycle in which the result is issued.
//   Result channel: o_result (result_value, out_of_range, last_out) is valid for
//   exactly one cycle, marked by o_result_valid. The receiver cannot stall it.
//   Configuration: register 0 is the exponent, register 1 the modulus, written
//   through i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data. o_cfg_ready
//   is low while busy or start is high, so the key cannot change mid-request.
// Sequence
//   One request at a time. Load, reduction of the message mod the modulus, init,
//   then per exponent bit up to the highest set bit: a load, shift-add steps (stops
//   once the multiplier is spent) and an update, then the issue step; the result is
//   on the ports in the cycle after it. The worst case is a full 62-bit exponent and
//   modulus, set by the product loop. The square and the multiply share the
//   multiplier bits and run side by side.
// Reset
//   Synchronous, active low: sequencer idle, no result pending, exponent 1, modulus 3.
module modular_exponentiation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mexp_pkg::t_req                   i_req,
    output logic                             o_result_valid,
    output mexp_pkg::t_result                o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [mexp_pkg::VALUE_W-1:0]     i_cfg_data
);
    import mexp_pkg::*;

    `include "modular_exponentiation_assert.svh"

    // Conditional subtract: x < 2m assumed, result below m
    function automatic logic [VALUE_W-1:0] reduce(input logic [VALUE_W:0]   x,
                                                  input logic [VALUE_W-1:0] m);
        logic [VALUE_W:0] diff;
        diff = x - {1'b0, m};
        return (x >= {1'b0, m}) ? diff[VALUE_W-1:0] : x[VALUE_W-1:0];
    endfunction

    // Key registers
    logic [VALUE_W-1:0] r_exponent, r_modulus;

    // Sequencer
    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          uw;
    logic            cond_ok;

    // Datapath
    logic [VALUE_W-1:0] r_shift, n_shift;   // message during reduction, multiplier later
    logic [VALUE_W-1:0] r_base,  n_base;    // remainder, then running base
    logic [VALUE_W-1:0] r_acc,   n_acc;
    logic [VALUE_W-1:0] r_exp,   n_exp;
    logic [VALUE_W-1:0] r_p1,    n_p1;      // acc * base
    logic [VALUE_W-1:0] r_p2,    n_p2;      // base * base
    logic [VALUE_W-1:0] r_a1,    n_a1;
    logic [VALUE_W-1:0] r_a2,    n_a2;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               r_flag,  n_flag;
    logic               r_last,  n_last;

    logic               r_res_valid, n_res_valid;
    t_result            r_res,       n_res;

    logic               accept;

    assign busy        = (r_pc != PC_IDLE);
    assign accept      = start && !busy;
    // no key write on the edge that takes a request
    assign o_cfg_ready = !busy && !start;

    assign uw = ucode(r_pc);

    always_comb begin
        case (uw.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_START:    cond_ok = start;
            COND_CNT_ZERO: cond_ok = (r_cnt == '0);
            COND_E_ZERO:   cond_ok = (r_exp == '0);
            COND_Y_LAST:   cond_ok = (r_shift[VALUE_W-1:1] == '0);
            COND_E_LAST:   cond_ok = (r_exp[VALUE_W-1:1] == '0);
            default:       cond_ok = 1'b1;
        endcase
        n_pc = cond_ok ? uw.tgt_t : uw.tgt_f;
    end

    always_comb begin
        n_shift     = r_shift;
        n_base      = r_base;
        n_acc       = r_acc;
        n_exp       = r_exp;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_a1        = r_a1;
        n_a2        = r_a2;
        n_cnt       = r_cnt;
        n_flag      = r_flag;
        n_last      = r_last;
        n_res_valid = 1'b0;
        n_res       = r_res;
        unique case (uw.op)
            OP_LOAD: begin
                if (accept) begin
                    n_shift = i_req.message;
                    n_last  = i_req.last_word;
                    n_flag  = (i_req.message >= r_modulus);
                    n_base  = '0;
                    n_exp   = r_exponent;
                    n_cnt   = CNT_W'(VALUE_W - 1);
                end
            end
            OP_REM: begin
                // restoring remainder, one message bit per step, MSB first
                n_base  = reduce({r_base, r_shift[VALUE_W-1]}, r_modulus);
                n_shift = {r_shift[VALUE_W-2:0], 1'b0};
                n_cnt   = r_cnt - 1'b1;
            end
            OP_INIT: begin
                n_acc = (r_modulus == ONE_VALUE) ? '0 : ONE_VALUE;
            end
            OP_MLOAD: begin
                n_shift = r_base;
                n_a1    = r_acc;
                n_a2    = r_base;
                n_p1    = '0;
                n_p2    = '0;
            end
            OP_MSTEP: begin
                if (r_shift[0]) begin
                    n_p1 = reduce({1'b0, r_p1} + {1'b0, r_a1}, r_modulus);
                    n_p2 = reduce({1'b0, r_p2} + {1'b0, r_a2}, r_modulus);
                end
                n_a1    = reduce({r_a1, 1'b0}, r_modulus);
                n_a2    = reduce({r_a2, 1'b0}, r_modulus);
                n_shift = {1'b0, r_shift[VALUE_W-1:1]};
            end
            OP_EUPD: begin
                if (r_exp[0]) begin
                    n_acc = r_p1;
                end
                n_base = r_p2;
                n_exp  = {1'b0, r_exp[VALUE_W-1:1]};
            end
            OP_EMIT: begin
                n_res_valid        = 1'b1;
                n_res.result_value = (r_modulus == '0) ? '0 : r_acc;
                n_res.out_of_range = r_flag;
                n_res.last_out     = r_last;
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_res_valid <= 1'b0;
            r_exponent  <= ONE_VALUE;
            r_modulus   <= VALUE_W'(3);
        end else begin
            r_pc        <= n_pc;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_EXPONENT) begin
                    r_exponent <= i_cfg_data;
                end else begin
                    r_modulus <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_base  <= n_base;
        r_acc   <= n_acc;
        r_exp   <= n_exp;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_a1    <= n_a1;
        r_a2    <= n_a2;
        r_cnt   <= n_cnt;
        r_flag  <= n_flag;
        r_last  <= n_last;
        r_res   <= n_res;
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

    `MEXP_ASSERT_NOW(a_res_below_mod, i_clk, i_rst_n, o_result_valid,
        (o_result.result_value < r_modulus) || (r_modulus == '0))
    `MEXP_ASSERT_NEXT(a_accept_to_rem, i_clk, i_rst_n, accept, r_pc == PC_REM)
    `MEXP_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    `MEXP_ASSERT_NEXT(a_rem_done, i_clk, i_rst_n, (r_pc == PC_REM) && (r_cnt == '0),
        r_pc == PC_INIT)
    `MEXP_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, r_pc == PC_EMIT,
        o_result_valid && !busy)

endmodule
